@@ design/tpc_pkg.sv @@
package tpc_pkg;

    localparam int unsigned HDR_LEN    = 16;
    localparam int unsigned COUNT_W    = 17;
    localparam logic [16:0] COUNT_MAX  = 17'h1ffff;
    localparam logic [15:0] NONE_FOUND = 16'hffff;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SIZE    = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_FLAGS   = 3'd4,
        ST_LENGTH  = 3'd5,
        ST_PAYLOAD = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        REG_MAGIC   = 2'd0,
        REG_VERSION = 2'd1,
        REG_FLAGS   = 2'd2,
        REG_PAYLOAD = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } pkt_byte_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] seq_number;
        logic [31:0] sample_number;
        logic [15:0] length_field;
        logic [15:0] bad_offset;
    } verdict_t;

endpackage

@@ design/test_packet_checker.sv @@
// Test packet checker.
// Bytes of one packet arrive on the pkt channel (pkt_valid/pkt_stall), one per
// transaction, with last_byte set on the final byte. The first 16 bytes form
// the header (magic, version, flags, length, sequence, sample index); the rest
// is payload that must follow the pattern (sequence + offset) mod 256.
// One verdict leaves on the res channel (res_valid/res_stall) for each packet,
// once registered in the result register (or the skid register while the
// receiver stalls). Bytes that are not last produce nothing. The block takes
// one byte per cycle while pkt_stall is low; each byte is checked in a single
// pass of logic from the per-packet state registers to the result register.
// The result register is backed by a one-entry skid register. While the
// receiver stalls, bytes keep being accepted; pkt_stall rises only once a
// second verdict has been parked in the skid register.
// Configuration is written through cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high. Writes are meant to happen only while no packet is in flight.
// Reset clears the configuration registers to zero, clears all per-packet
// state and empties both result registers.
module test_packet_checker
    import tpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pkt_valid,
    output logic      pkt_stall,
    input  pkt_byte_t pkt,
    output logic      res_valid,
    input  logic      res_stall,
    output verdict_t  res,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  cfg_reg_t  cfg_index,
    input  logic [31:0] cfg_data
);

    // Configuration registers.
    logic [31:0] magic_word_reg;
    logic [7:0]  version_reg;
    logic [7:0]  flag_byte_reg;
    logic [15:0] payload_size_reg;

    // Per-packet state.
    logic [16:0] byte_count_reg,  byte_count_next;
    status_t     header_err_reg,  header_err_next;
    logic [31:0] magic_shift_reg, magic_shift_next;
    logic [31:0] seq_num_reg,     seq_num_next;
    logic [31:0] sample_num_reg,  sample_num_next;
    logic [15:0] length_reg,      length_next;
    logic [15:0] first_bad_reg,   first_bad_next;
    logic        overflowed_reg,  overflowed_next;

    // State after the current byte, before the end-of-packet clear.
    status_t     header_err_upd;
    logic [31:0] magic_shift_upd;
    logic [31:0] seq_num_upd;
    logic [31:0] sample_num_upd;
    logic [15:0] length_upd;
    logic [15:0] first_bad_upd;

    // Output stage.
    verdict_t out_reg, out_next;
    logic     out_valid_reg, out_valid_next;
    verdict_t skid_reg, skid_next;
    logic     skid_valid_reg, skid_valid_next;

    verdict_t    verdict;
    logic        pkt_fire;
    logic        res_fire;
    logic        verdict_fire;
    logic        size_bad;
    logic [16:0] p;
    logic [7:0]  b;
    logic [7:0]  want;
    logic [31:0] magic_cand;
    logic [15:0] length_cand;

    assign pkt_stall = skid_valid_reg;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign cfg_ready = 1'b1;

    assign pkt_fire     = pkt_valid && !pkt_stall;
    assign res_fire     = out_valid_reg && !res_stall;
    assign verdict_fire = pkt_fire && pkt.last_byte;

    assign p = byte_count_reg;
    assign b = pkt.data_byte;
    assign magic_cand  = {magic_shift_reg[23:0], b};
    assign length_cand = {length_reg[15:8], b};
    // Payload offset is p - 16; only its low byte matters for the pattern.
    assign want = seq_num_reg[7:0] + p[7:0] - 8'(HDR_LEN);

    // Apply the current byte to the header and payload checks.
    always_comb
    begin
        header_err_upd  = header_err_reg;
        magic_shift_upd = magic_shift_reg;
        seq_num_upd     = seq_num_reg;
        sample_num_upd  = sample_num_reg;
        length_upd      = length_reg;
        first_bad_upd   = first_bad_reg;
        if (!overflowed_reg)
        begin
            if (p < 17'd4)
            begin
                magic_shift_upd = magic_cand;
                if (p == 17'd3 && magic_cand != magic_word_reg &&
                    header_err_reg == ST_OK)
                begin
                    header_err_upd = ST_MAGIC;
                end
            end
            else if (p == 17'd4)
            begin
                if (b != version_reg && header_err_reg == ST_OK)
                begin
                    header_err_upd = ST_VERSION;
                end
            end
            else if (p == 17'd5)
            begin
                if (b != flag_byte_reg && header_err_reg == ST_OK)
                begin
                    header_err_upd = ST_FLAGS;
                end
            end
            else if (p == 17'd6)
            begin
                length_upd = {b, 8'h00};
            end
            else if (p == 17'd7)
            begin
                length_upd = length_cand;
                if (length_cand != payload_size_reg && header_err_reg == ST_OK)
                begin
                    header_err_upd = ST_LENGTH;
                end
            end
            else if (p < 17'd12)
            begin
                seq_num_upd = {seq_num_reg[23:0], b};
            end
            else if (p < 17'(HDR_LEN))
            begin
                sample_num_upd = {sample_num_reg[23:0], b};
            end
            else
            begin
                // Offsets of 65535 and beyond are never recorded.
                if (p < 17'(HDR_LEN) + {1'b0, NONE_FOUND} && b != want &&
                    first_bad_reg == NONE_FOUND)
                begin
                    first_bad_upd = 16'(p - 17'(HDR_LEN));
                end
            end
        end
    end

    // Verdict for a packet that ends with the current byte.
    always_comb
    begin
        size_bad = overflowed_reg ||
                   (p != {1'b0, payload_size_reg} + 17'(HDR_LEN - 1));
        if (size_bad)
        begin
            verdict.status = ST_SIZE;
        end
        else if (header_err_upd != ST_OK)
        begin
            verdict.status = header_err_upd;
        end
        else if (first_bad_upd != NONE_FOUND)
        begin
            verdict.status = ST_PAYLOAD;
        end
        else
        begin
            verdict.status = ST_OK;
        end
        if (verdict.status == ST_OK || verdict.status == ST_PAYLOAD)
        begin
            verdict.seq_number    = seq_num_upd;
            verdict.sample_number = sample_num_upd;
            verdict.length_field  = length_upd;
        end
        else
        begin
            verdict.seq_number    = '0;
            verdict.sample_number = '0;
            verdict.length_field  = '0;
        end
        verdict.bad_offset = (verdict.status == ST_PAYLOAD) ? first_bad_upd : NONE_FOUND;
    end

    // Per-packet state: advance on each byte, clear after the last one.
    always_comb
    begin
        byte_count_next  = byte_count_reg;
        header_err_next  = header_err_reg;
        magic_shift_next = magic_shift_reg;
        seq_num_next     = seq_num_reg;
        sample_num_next  = sample_num_reg;
        length_next      = length_reg;
        first_bad_next   = first_bad_reg;
        overflowed_next  = overflowed_reg;
        if (pkt_fire)
        begin
            if (pkt.last_byte)
            begin
                byte_count_next  = '0;
                header_err_next  = ST_OK;
                magic_shift_next = '0;
                seq_num_next     = '0;
                sample_num_next  = '0;
                length_next      = '0;
                first_bad_next   = NONE_FOUND;
                overflowed_next  = 1'b0;
            end
            else
            begin
                header_err_next  = header_err_upd;
                magic_shift_next = magic_shift_upd;
                seq_num_next     = seq_num_upd;
                sample_num_next  = sample_num_upd;
                length_next      = length_upd;
                first_bad_next   = first_bad_upd;
                if (byte_count_reg >= COUNT_MAX)
                begin
                    overflowed_next = 1'b1;
                end
                else
                begin
                    byte_count_next = byte_count_reg + 17'd1;
                end
            end
        end
    end

    // Result register with a one-entry skid behind it.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (res_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (verdict_fire)
        begin
            if (!out_valid_reg || res_fire)
            begin
                out_next       = verdict;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = verdict;
                skid_valid_next = 1'b1;
            end
        end
        else if (res_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg   <= '0;
            version_reg      <= '0;
            flag_byte_reg    <= '0;
            payload_size_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAGIC:   magic_word_reg   <= cfg_data;
                REG_VERSION: version_reg      <= cfg_data[7:0];
                REG_FLAGS:   flag_byte_reg    <= cfg_data[7:0];
                REG_PAYLOAD: payload_size_reg <= cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            header_err_reg  <= ST_OK;
            magic_shift_reg <= '0;
            seq_num_reg     <= '0;
            sample_num_reg  <= '0;
            length_reg      <= '0;
            first_bad_reg   <= NONE_FOUND;
            overflowed_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            header_err_reg  <= header_err_next;
            magic_shift_reg <= magic_shift_next;
            seq_num_reg     <= seq_num_next;
            sample_num_reg  <= sample_num_next;
            length_reg      <= length_next;
            first_bad_reg   <= first_bad_next;
            overflowed_reg  <= overflowed_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

@@ tb/packet_verdict_checker.sv @@
module packet_verdict_checker
    import tpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pkt_valid,
    input  logic        pkt_stall,
    input  pkt_byte_t   pkt,
    input  logic        res_valid,
    input  logic        res_stall,
    input  verdict_t    res,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  cfg_reg_t    cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the configuration registers.
    logic [31:0] magic_cfg;
    logic [7:0]  version_cfg;
    logic [7:0]  flags_cfg;
    logic [15:0] size_cfg;

    // Per-packet parsing state.
    logic [16:0] byte_cnt;
    status_t     hdr_err;
    logic [31:0] magic_acc;
    logic [31:0] seq_acc;
    logic [31:0] sample_acc;
    logic [15:0] len_acc;
    logic [15:0] bad_off;
    logic        saturated;

    verdict_t    verdict_q[$];

    task automatic clear_packet();
        byte_cnt   = '0;
        hdr_err    = ST_OK;
        magic_acc  = '0;
        seq_acc    = '0;
        sample_acc = '0;
        len_acc    = '0;
        bad_off    = NONE_FOUND;
        saturated  = 1'b0;
    endtask

    task automatic note_header(input status_t code);
        if (hdr_err == ST_OK)
        begin
            hdr_err = code;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] seen);
        if (seen !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [16:0] pos;
        logic [16:0] off;
        logic [7:0]  b;
        logic [7:0]  want;
        status_t     st;
        verdict_t    v;

        if (!rst_n)
        begin
            magic_cfg   = '0;
            version_cfg = '0;
            flags_cfg   = '0;
            size_cfg    = '0;
            clear_packet();
            verdict_q.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MAGIC:   magic_cfg   = cfg_data;
                    REG_VERSION: version_cfg = cfg_data[7:0];
                    REG_FLAGS:   flags_cfg   = cfg_data[7:0];
                    REG_PAYLOAD: size_cfg    = cfg_data[15:0];
                    default:     ;
                endcase
            end

            if (pkt_valid && !pkt_stall)
            begin
                pos = byte_cnt;
                b   = pkt.data_byte;
                if (!saturated)
                begin
                    if (pos < 17'd4)
                    begin
                        magic_acc = {magic_acc[23:0], b};
                        if (pos == 17'd3 && magic_acc != magic_cfg)
                        begin
                            note_header(ST_MAGIC);
                        end
                    end
                    else if (pos == 17'd4)
                    begin
                        if (b != version_cfg)
                        begin
                            note_header(ST_VERSION);
                        end
                    end
                    else if (pos == 17'd5)
                    begin
                        if (b != flags_cfg)
                        begin
                            note_header(ST_FLAGS);
                        end
                    end
                    else if (pos == 17'd6)
                    begin
                        len_acc = {b, 8'h00};
                    end
                    else if (pos == 17'd7)
                    begin
                        len_acc[7:0] = b;
                        if (len_acc != size_cfg)
                        begin
                            note_header(ST_LENGTH);
                        end
                    end
                    else if (pos < 17'd12)
                    begin
                        seq_acc = {seq_acc[23:0], b};
                    end
                    else if (pos < 17'(HDR_LEN))
                    begin
                        sample_acc = {sample_acc[23:0], b};
                    end
                    else
                    begin
                        // Payload offsets from 65535 on are never recorded.
                        off  = pos - 17'(HDR_LEN);
                        want = seq_acc[7:0] + off[7:0];
                        if (off < 17'(NONE_FOUND) && b != want && bad_off == NONE_FOUND)
                        begin
                            bad_off = off[15:0];
                        end
                    end
                end

                if (!pkt.last_byte)
                begin
                    if (byte_cnt >= COUNT_MAX)
                    begin
                        saturated = 1'b1;
                    end
                    else
                    begin
                        byte_cnt = byte_cnt + 17'd1;
                    end
                end
                else
                begin
                    if (saturated || (18'(pos) + 18'd1 != 18'(HDR_LEN) + 18'(size_cfg)))
                    begin
                        st = ST_SIZE;
                    end
                    else if (hdr_err != ST_OK)
                    begin
                        st = hdr_err;
                    end
                    else if (bad_off != NONE_FOUND)
                    begin
                        st = ST_PAYLOAD;
                    end
                    else
                    begin
                        st = ST_OK;
                    end

                    v.status = st;
                    if (st == ST_OK || st == ST_PAYLOAD)
                    begin
                        v.seq_number    = seq_acc;
                        v.sample_number = sample_acc;
                        v.length_field  = len_acc;
                    end
                    else
                    begin
                        v.seq_number    = '0;
                        v.sample_number = '0;
                        v.length_field  = '0;
                    end
                    v.bad_offset = (st == ST_PAYLOAD) ? bad_off : NONE_FOUND;
                    verdict_q.push_back(v);
                    clear_packet();
                end
            end

            if (res_valid && !res_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: verdict mismatch, expected none, actual status %0d seq %0h",
                             $time, res.status, res.seq_number);
                    fail_count++;
                end
                else
                begin
                    v = verdict_q.pop_front();
                    compare_field("status", 32'(v.status), 32'(res.status));
                    compare_field("seq_number", v.seq_number, res.seq_number);
                    compare_field("sample_number", v.sample_number, res.sample_number);
                    compare_field("length_field", 32'(v.length_field), 32'(res.length_field));
                    compare_field("bad_offset", 32'(v.bad_offset), 32'(res.bad_offset));
                end
            end

            outstanding = verdict_q.size();
        end
    end

endmodule

@@ tb/tb.sv @@
module tb
    import tpc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int RANDOM_BYTES = 1350;

    typedef enum int {
        FR_GOOD,
        FR_PAYLOAD,
        FR_HEADER,
        FR_SIZE,
        FR_NOISE
    } frame_kind_t;

    typedef enum int {
        RS_NONE,
        RS_LIGHT,
        RS_HEAVY,
        RS_TOGGLE
    } stall_mode_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        pkt_valid = 1'b0;
    pkt_byte_t   pkt       = '0;
    logic        res_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    cfg_reg_t    cfg_index = REG_MAGIC;
    logic [31:0] cfg_data  = '0;

    logic        pkt_stall;
    logic        res_valid;
    verdict_t    res;
    logic        cfg_ready;

    int          fail_count;
    int          outstanding;

    int          cycles     = 0;
    int          burst_left = 0;
    stall_mode_t stall_mode = RS_NONE;
    int          stall_left = 0;

    logic [31:0] cur_magic;
    logic [7:0]  cur_version;
    logic [7:0]  cur_flags;
    logic [15:0] cur_size;
    logic [7:0]  frame[$];

    test_packet_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    packet_verdict_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .pkt_valid   (pkt_valid),
        .pkt_stall   (pkt_stall),
        .pkt         (pkt),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5ns clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // The receiver switches between stall patterns, holding each one for a random stretch.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 300);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            RS_NONE:   res_stall <= 1'b0;
            RS_LIGHT:  res_stall <= ($urandom_range(0, 3) == 0);
            RS_HEAVY:  res_stall <= ($urandom_range(0, 3) != 0);
            default:   res_stall <= cycles[2];
        endcase
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_settings(input logic [31:0] m, input logic [7:0] v,
                                  input logic [7:0] f, input logic [15:0] s);
        cur_magic   = m;
        cur_version = v;
        cur_flags   = f;
        cur_size    = s;
        write_reg(REG_MAGIC, m);
        write_reg(REG_VERSION, 32'(v));
        write_reg(REG_FLAGS, 32'(f));
        write_reg(REG_PAYLOAD, 32'(s));
    endtask

    // Stops sending and waits until every verdict has come back.
    task automatic drain();
        pkt_valid = 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_value(input logic [31:0] top);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return top;
            default: return $urandom & top;
        endcase
    endfunction

    task automatic make_frame(input frame_kind_t kind);
        logic [31:0] seq;
        logic [31:0] sample;
        int          idx;
        int          new_len;

        seq    = $urandom;
        sample = $urandom;
        frame.delete();
        if (kind == FR_NOISE)
        begin
            repeat ($urandom_range(1, 60)) frame.push_back(8'($urandom));
            return;
        end

        for (int k = 0; k < 4; k++)
        begin
            frame.push_back(cur_magic[31 - 8 * k -: 8]);
        end
        frame.push_back(cur_version);
        frame.push_back(cur_flags);
        frame.push_back(cur_size[15:8]);
        frame.push_back(cur_size[7:0]);
        for (int k = 0; k < 4; k++)
        begin
            frame.push_back(seq[31 - 8 * k -: 8]);
        end
        for (int k = 0; k < 4; k++)
        begin
            frame.push_back(sample[31 - 8 * k -: 8]);
        end
        for (int k = 0; k < int'(cur_size); k++)
        begin
            frame.push_back(seq[7:0] + 8'(k));
        end

        case (kind)
            FR_PAYLOAD:
            begin
                if (cur_size != 0)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        idx = 16 + $urandom_range(0, int'(cur_size) - 1);
                        frame[idx] = frame[idx] ^ 8'($urandom_range(1, 255));
                    end
                end
            end
            FR_HEADER:
            begin
                // Sometimes two fields are broken, so the first one seen must win.
                repeat ($urandom_range(1, 2))
                begin
                    case ($urandom_range(0, 3))
                        0:       idx = $urandom_range(0, 3);
                        1:       idx = 4;
                        2:       idx = 5;
                        default: idx = $urandom_range(6, 7);
                    endcase
                    frame[idx] = frame[idx] ^ 8'($urandom_range(1, 255));
                end
            end
            FR_SIZE:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                        new_len = $urandom_range(1, 15);
                    else
                        new_len = $urandom_range(1, frame.size() - 1);
                    while (frame.size() > new_len) void'(frame.pop_back());
                end
                else
                begin
                    repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom));
                end
            end
            default: ;
        endcase
    endtask

    // One byte per transaction; the sender runs in bursts with random gaps.
    task automatic send_frame();
        int gap;

        for (int k = 0; k < frame.size(); k++)
        begin
            pkt_valid      = 1'b1;
            pkt.data_byte  = frame[k];
            pkt.last_byte  = (k == frame.size() - 1);
            do @(posedge clk); while (pkt_stall);
            @(negedge clk);
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    pkt_valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
                burst_left = $urandom_range(0, 40);
            end
        end
    endtask

    initial
    begin
        int          random_bytes;
        int          roll;
        frame_kind_t kind;
        logic [15:0] size_pick;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed packets at extreme settings.
        apply_settings(32'hffff_ffff, 8'hff, 8'h00, 16'd2);
        make_frame(FR_GOOD);
        send_frame();
        make_frame(FR_GOOD);
        frame[17] = frame[17] ^ 8'h01;
        send_frame();
        // Shorter than the header, with a bad magic byte among those that came.
        make_frame(FR_GOOD);
        frame[0] = frame[0] ^ 8'h80;
        while (frame.size() > 5) void'(frame.pop_back());
        send_frame();
        make_frame(FR_GOOD);
        while (frame.size() > 1) void'(frame.pop_back());
        send_frame();
        drain();

        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 5) == 0)
                size_pick = 16'($urandom_range(240, 300));
            else
                size_pick = 16'($urandom_range(0, 40));
            apply_settings(pick_value(32'hffff_ffff), 8'(pick_value(32'hff)),
                           8'(pick_value(32'hff)), size_pick);
            repeat ((size_pick > 100) ? $urandom_range(1, 2) : $urandom_range(3, 8))
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    kind = FR_GOOD;
                else if (roll < 70)
                    kind = FR_PAYLOAD;
                else if (roll < 85)
                    kind = FR_HEADER;
                else if (roll < 95)
                    kind = FR_SIZE;
                else
                    kind = FR_NOISE;
                make_frame(kind);
                random_bytes += frame.size();
                send_frame();
                if ($urandom_range(0, 9) == 0)
                begin
                    drain();
                end
            end
            drain();
        end

        apply_settings(32'h0, 8'h00, 8'hff, 16'd0);
        repeat (6)
        begin
            make_frame(frame_kind_t'($urandom_range(0, 4)));
            send_frame();
        end
        drain();

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
